FILE: sv/fixed_chunk_pool_allocator_defines.svh
// Assertion macros for the fixed chunk pool allocator.
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset
`define FCPA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Condition that must never hold outside reset
`define FCPA_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define FCPA_ASSERT(lbl, prop, msg)
`define FCPA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: sv/fcpa_pkg.sv
// Shared types and constants of the fixed chunk pool allocator.
`default_nettype none

package fcpa_pkg;

   // Field widths
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 17;
   localparam int COUNT_W = 7;
   localparam int USED_W  = 7;

   // Configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_SIZE  = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   // Register reset values
   localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd4096;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd64;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   // Built capacity
   localparam int DEFAULT_MAX_CHUNKS = 64;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [ADDR_W-1:0]  chunk_address;
      logic [SIZE_W-1:0]  granted_size;
      logic [USED_W-1:0]  used_chunks;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/fixed_chunk_pool_allocator.sv
// Fixed-size chunk pool allocator: LIFO free stack, allocation map, shared 32-bit adder.
//
// A request is taken when start is high and busy is low; its single result is shown on
// rsp_data for exactly one cycle with rsp_strobe high, and the receiver cannot stall it.
// Request and result fields are req_type/rsp_type from fcpa_pkg. A request that fails
// at once (allocate on an empty pool, free of address zero or with no chunks) answers
// in the next cycle. An allocate does one stack memory read, then shift-and-add steps
// of the shared adder forming base + index * size. A free scans the allocation map one
// chunk per cycle with the same adder stepping the chunk address. After reset and after
// every write to the base, size or count register the allocation map is cleared entry
// by entry, during which busy is high; registers remain writable meanwhile.
`default_nettype none
`include "fixed_chunk_pool_allocator_defines.svh"

module fixed_chunk_pool_allocator #(
   parameter int MAX_CHUNKS = fcpa_pkg::DEFAULT_MAX_CHUNKS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  fcpa_pkg::req_type            req_data,
   // result channel
   output logic                         rsp_strobe,
   output fcpa_pkg::rsp_type            rsp_data,
   // register port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fcpa_pkg::CSR_AW-1:0]  paddr,
   input  logic [fcpa_pkg::CSR_DW-1:0]  pwdata,
   output logic [fcpa_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import fcpa_pkg::*;

   localparam int IDX_W   = $clog2(MAX_CHUNKS);
   localparam int DEPTH_W = $clog2(MAX_CHUNKS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHUNKS - 1);
   localparam logic [IDX_W-1:0] MUL_LAST = IDX_W'(IDX_W - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_POP   = 5'b00100,
      S_MUL   = 5'b01000,
      S_SCAN  = 5'b10000
   } state_type;

   // Control registers
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [DEPTH_W-1:0]   min_depth_ff, min_depth_in;
   logic [USED_W-1:0]    in_use_ff, in_use_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   // Datapath registers
   logic [ADDR_W-1:0]    acc_ff, acc_in;
   logic [ADDR_W-1:0]    sz_sh_ff, sz_sh_in;
   logic [IDX_W-1:0]     mul_ff, mul_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   rsp_type              rsp_ff, rsp_in;

   // Memories
   logic [IDX_W-1:0]     stack_mem [MAX_CHUNKS];
   logic                 map_mem   [MAX_CHUNKS];
   logic [IDX_W-1:0]     stack_rd_ff;
   logic                 map_rd_ff;
   logic [IDX_W-1:0]     stack_raddr, stack_waddr, stack_wdata;
   logic                 stack_we;
   logic [IDX_W-1:0]     map_raddr, map_waddr;
   logic                 map_we, map_wdata;

   logic                 csr_wr;
   logic [1:0]           csr_idx;
   logic                 rebuild;
   logic [DEPTH_W-1:0]   pool_chunks;
   logic [ADDR_W-1:0]    add_b, sum;
   logic [DEPTH_W-1:0]   pos;
   logic [IDX_W-1:0]     pop_idx;
   logic                 hit;

   // Register port
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[CSR_AW-1:2];
   assign pready  = 1'b1;
   assign rebuild = csr_wr &&
                    (csr_idx == REG_BASE || csr_idx == REG_SIZE || csr_idx == REG_COUNT);

   always_comb begin
      base_in  = base_ff;
      size_in  = size_ff;
      count_in = count_ff;
      prdata   = '0;
      unique case (csr_idx)
         REG_BASE: begin
            prdata = base_ff;
            if (csr_wr) base_in = pwdata;
         end
         REG_SIZE: begin
            prdata = CSR_DW'(size_ff);
            if (csr_wr) size_in = pwdata[SIZE_W-1:0];
         end
         REG_COUNT: begin
            prdata = CSR_DW'(count_ff);
            if (csr_wr) count_in = pwdata[COUNT_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Pool is capped at the built capacity
   always_comb begin
      if (32'(count_ff) < 32'(MAX_CHUNKS)) begin
         pool_chunks = DEPTH_W'(count_ff);
      end else begin
         pool_chunks = DEPTH_W'(MAX_CHUNKS);
      end
   end

   // Shared adder: multiply steps in S_MUL, address stepping otherwise
   always_comb begin
      if (state_ff == S_MUL) begin
         add_b = mul_ff[0] ? sz_sh_ff : '0;
      end else begin
         add_b = ADDR_W'(size_ff);
      end
   end
   assign sum = acc_ff + add_b;

   // Stack slots below the lowest depth since rebuild still hold their own index
   assign pos     = depth_ff - DEPTH_W'(1);
   assign pop_idx = (pos < min_depth_ff) ? pos[IDX_W-1:0] : stack_rd_ff;
   assign hit     = map_rd_ff && (acc_ff == addr_ff);

   assign stack_raddr = pos[IDX_W-1:0];
   assign map_raddr   = (state_ff == S_IDLE) ? '0 : cnt_ff + IDX_W'(1);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      depth_in      = depth_ff;
      min_depth_in  = min_depth_ff;
      in_use_in     = in_use_ff;
      rsp_strobe_in = 1'b0;
      acc_in        = acc_ff;
      sz_sh_in      = sz_sh_ff;
      mul_in        = mul_ff;
      addr_in       = addr_ff;
      rsp_in        = rsp_ff;
      map_we        = 1'b0;
      map_waddr     = cnt_ff;
      map_wdata     = 1'b0;
      stack_we      = 1'b0;
      stack_waddr   = depth_ff[IDX_W-1:0];
      stack_wdata   = cnt_ff;

      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = cnt_ff;
            map_wdata = 1'b0;
            cnt_in    = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in     = S_IDLE;
               depth_in     = pool_chunks;
               min_depth_in = pool_chunks;
               in_use_in    = '0;
            end
         end
         S_IDLE: begin
            if (start) begin
               addr_in = req_data.address;
               rsp_in  = '{ok: 1'b0, chunk_address: '0, granted_size: '0,
                            used_chunks: in_use_ff};
               if (req_data.kind == KIND_ALLOC) begin
                  if (depth_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = S_POP;
                  end
               end else begin
                  if (req_data.address == '0 || pool_chunks == '0) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     acc_in   = base_ff;
                     cnt_in   = '0;
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_POP: begin
            map_we    = 1'b1;
            map_waddr = pop_idx;
            map_wdata = 1'b1;
            depth_in  = pos;
            if (pos < min_depth_ff) min_depth_in = pos;
            in_use_in = in_use_ff + USED_W'(1);
            acc_in    = base_ff;
            mul_in    = pop_idx;
            sz_sh_in  = ADDR_W'(size_ff);
            cnt_in    = '0;
            state_in  = S_MUL;
         end
         S_MUL: begin
            acc_in   = sum;
            mul_in   = mul_ff >> 1;
            sz_sh_in = sz_sh_ff << 1;
            cnt_in   = cnt_ff + IDX_W'(1);
            if (cnt_ff == MUL_LAST) begin
               rsp_in        = '{ok: 1'b1, chunk_address: sum, granted_size: size_ff,
                                 used_chunks: in_use_ff};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            if (hit) begin
               // release the chunk and push its index back
               map_we      = 1'b1;
               map_waddr   = cnt_ff;
               map_wdata   = 1'b0;
               stack_we    = 1'b1;
               stack_waddr = depth_ff[IDX_W-1:0];
               stack_wdata = cnt_ff;
               depth_in    = depth_ff + DEPTH_W'(1);
               if (in_use_ff != '0) in_use_in = in_use_ff - USED_W'(1);
               rsp_in = '{ok: 1'b1, chunk_address: '0, granted_size: '0,
                          used_chunks: (in_use_ff != '0) ? in_use_ff - USED_W'(1)
                                                         : in_use_ff};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (DEPTH_W'(cnt_ff) + DEPTH_W'(1) == pool_chunks) begin
               // no allocated chunk at that address
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               acc_in = sum;
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase

      // a write to the base, size or count register rebuilds the pool
      if (rebuild) begin
         state_in = S_CLEAR;
         cnt_in   = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         depth_ff      <= '0;
         min_depth_ff  <= '0;
         in_use_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         base_ff       <= BASE_RESET;
         size_ff       <= SIZE_RESET;
         count_ff      <= COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         depth_ff      <= depth_in;
         min_depth_ff  <= min_depth_in;
         in_use_ff     <= in_use_in;
         rsp_strobe_ff <= rsp_strobe_in;
         base_ff       <= base_in;
         size_ff       <= size_in;
         count_ff      <= count_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      sz_sh_ff <= sz_sh_in;
      mul_ff   <= mul_in;
      addr_ff  <= addr_in;
      rsp_ff   <= rsp_in;
   end

   // Free stack memory
   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   // Allocation map memory
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[map_raddr];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   `FCPA_ASSERT_NEVER(a_stack_floor, min_depth_ff > depth_ff, "stack floor above depth")
   `FCPA_ASSERT(a_size_needs_ok, rsp_strobe && (rsp_data.granted_size != '0) |-> rsp_data.ok, "size granted on a failed request")
   `FCPA_ASSERT(a_busy_cause, $rose(busy) |-> $past(start) || $past(csr_wr), "busy without request or register write")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the fixed chunk pool allocator: directed steps, then random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fcpa_pkg::*;

   localparam int CAPACITY = DEFAULT_MAX_CHUNKS;
   localparam int LIMIT    = 500000;
   localparam int SEGMENTS = 10;
   localparam int SEG_REQS = 52;
   localparam int MAX_GAP  = 80;
   // register index with no register behind it
   localparam logic [1:0] REG_SPARE = 2'd3;

   // one line of the directed plan: a register write or a request
   typedef struct packed {
      logic        is_write;
      logic [1:0]  reg_idx;
      logic [31:0] value;
      req_type     item;
      logic        typed;
      rsp_type     want;
   } plan_step_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // typed-in expectation travelling with the current request
   logic                fixed_valid;
   rsp_type             fixed_rsp;

   // shadow of the pool
   logic [31:0]         pool_base;
   logic [16:0]         pool_csize;
   logic [6:0]          pool_ccount;
   int                  free_idx [CAPACITY];
   bit                  taken [CAPACITY];
   int                  free_depth;
   int                  in_use;
   int                  pool_n;

   rsp_type             due_replies [$];
   plan_step_type       plan [$];
   int                  mismatches;
   int                  cycle_count;

   fixed_chunk_pool_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #4 clock = ~clock;

   task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want_v);
      mismatches++;
   endtask

   // address of chunk idx, wrapping at 32 bits
   function automatic logic [31:0] chunk_at(int idx);
      return pool_base + (32'(idx) * {15'd0, pool_csize});
   endfunction

   // every chunk free, highest index on top
   function automatic void refill_pool();
      pool_n = (pool_ccount < CAPACITY) ? int'(pool_ccount) : CAPACITY;
      for (int i = 0; i < CAPACITY; i++) begin
         free_idx[i] = i;
         taken[i] = 1'b0;
      end
      free_depth = pool_n;
      in_use = 0;
   endfunction

   // register write; the unused index leaves the pool alone
   function automatic void retune_pool(logic [1:0] idx, logic [31:0] v);
      if (idx != REG_SPARE) begin
         case (idx)
            REG_BASE: pool_base = v;
            REG_SIZE: pool_csize = v[16:0];
            default: pool_ccount = v[6:0];
         endcase
         refill_pool();
      end
   endfunction

   // outcome of one request, advancing the shadow pool
   function automatic rsp_type predict_pool_op(req_type r);
      rsp_type o;
      int idx;
      o = '0;
      if (r.kind == KIND_ALLOC) begin
         if (free_depth > 0) begin
            free_depth--;
            idx = free_idx[free_depth];
            taken[idx] = 1'b1;
            in_use++;
            o.ok = 1'b1;
            o.chunk_address = chunk_at(idx);
            o.granted_size = pool_csize;
         end
      end else if (r.address != 0) begin
         // lowest matching allocated chunk goes back on the stack
         for (int i = 0; i < pool_n && !o.ok; i++) begin
            if (taken[i] && chunk_at(i) == r.address) begin
               taken[i] = 1'b0;
               if (in_use > 0) in_use--;
               if (free_depth < CAPACITY) begin
                  free_idx[free_depth] = i;
                  free_depth++;
               end
               o.ok = 1'b1;
            end
         end
      end
      o.used_chunks = USED_W'(in_use);
      return o;
   endfunction

   // random request; its frees mostly name chunks that are really held
   function automatic req_type random_request(int alloc_pct);
      req_type r;
      int held [$];
      int roll;
      r.kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
      r.address = $urandom;
      if (r.kind == KIND_FREE) begin
         for (int i = 0; i < pool_n; i++) if (taken[i]) held = {held, i};
         roll = $urandom_range(0, 99);
         if (roll < 70 && held.size() > 0) begin
            r.address = chunk_at(held[$urandom_range(0, held.size() - 1)]);
         end else if (roll < 80 && pool_n > 0) begin
            // chunk of the pool, often not held
            r.address = chunk_at($urandom_range(0, pool_n - 1));
         end else if (roll < 88) begin
            r.address = '0;
         end else if (roll < 94 && pool_n > 0) begin
            r.address = chunk_at($urandom_range(0, pool_n - 1)) + $urandom_range(1, 3);
         end
      end
      return r;
   endfunction

   function automatic plan_step_type step_req(logic kind, logic [31:0] addr);
      plan_step_type s;
      s = '0;
      s.item.kind = kind;
      s.item.address = addr;
      return s;
   endfunction

   function automatic plan_step_type step_chk(logic kind, logic [31:0] addr, logic ok,
                                              logic [31:0] caddr, logic [16:0] size,
                                              logic [6:0] used);
      plan_step_type s;
      s = step_req(kind, addr);
      s.typed = 1'b1;
      s.want.ok = ok;
      s.want.chunk_address = caddr;
      s.want.granted_size = size;
      s.want.used_chunks = used;
      return s;
   endfunction

   function automatic plan_step_type step_cfg(logic [1:0] idx, logic [31:0] v);
      plan_step_type s;
      s = '0;
      s.is_write = 1'b1;
      s.reg_idx = idx;
      s.value = v;
      return s;
   endfunction

   // append one line to the directed plan
   function automatic void add_step(plan_step_type s);
      plan = {plan, s};
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(req_type r, logic typed, rsp_type want, int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
      end
      start = 1'b1;
      req_data = r;
      fixed_valid = typed;
      fixed_rsp = want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // register write once the pool is quiet, then read back unless the index is unused
   task automatic write_register(logic [1:0] idx, logic [31:0] v);
      logic [31:0] want_v;
      start = 1'b0;
      fixed_valid = 1'b0;
      while (due_replies.size() != 0 || busy) @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      retune_pool(idx, v);
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      if (idx == REG_SPARE) begin
         psel = 1'b0;
      end else begin
         @(negedge clock);
         penable = 1'b1;
         @(posedge clock);
         case (idx)
            REG_BASE: want_v = pool_base;
            REG_SIZE: want_v = {15'd0, pool_csize};
            default: want_v = {25'd0, pool_ccount};
         endcase
         if (prdata !== want_v) note_mismatch("register readback", prdata, want_v);
         @(negedge clock);
         psel = 1'b0;
         penable = 1'b0;
      end
   endtask

   // prediction on acceptance, then comparison of any result
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = predict_pool_op(req_data);
            due_replies = {due_replies, fixed_valid ? fixed_rsp : want};
         end
         if (rsp_strobe) begin
            if (due_replies.size() == 0) begin
               note_mismatch("unexpected result, ok", 32'(rsp_data.ok), 32'd0);
            end else begin
               want = due_replies.pop_front();
               if (rsp_data.ok !== want.ok)
                  note_mismatch("ok", 32'(rsp_data.ok), 32'(want.ok));
               if (rsp_data.chunk_address !== want.chunk_address)
                  note_mismatch("chunk_address", rsp_data.chunk_address, want.chunk_address);
               if (rsp_data.granted_size !== want.granted_size)
                  note_mismatch("granted_size", 32'(rsp_data.granted_size),
                                32'(want.granted_size));
               if (rsp_data.used_chunks !== want.used_chunks)
                  note_mismatch("used_chunks", 32'(rsp_data.used_chunks),
                                32'(want.used_chunks));
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      int alloc_pct;
      int idle_pct;
      logic [31:0] base_v;
      logic [31:0] size_v;
      logic [31:0] count_v;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fixed_valid = 1'b0;
      fixed_rsp = '0;
      mismatches = 0;
      pool_base = BASE_RESET;
      pool_csize = SIZE_RESET;
      pool_ccount = COUNT_RESET;
      refill_pool();

      // reset pool: 64 chunks of 64 bytes from 4096
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd8128, 17'd64, 7'd1));
      add_step(step_chk(KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'd8064, 17'd64, 7'd2));
      add_step(step_chk(KIND_FREE, 32'd8128, 1'b1, 32'd0, 17'd0, 7'd1));
      // double free, address zero, unknown and misaligned addresses
      add_step(step_chk(KIND_FREE, 32'd8128, 1'b0, 32'd0, 17'd0, 7'd1));
      add_step(step_chk(KIND_FREE, 32'd0, 1'b0, 32'd0, 17'd0, 7'd1));
      add_step(step_chk(KIND_FREE, 32'hFFFF_FFFF, 1'b0, 32'd0, 17'd0, 7'd1));
      add_step(step_chk(KIND_FREE, 32'd8065, 1'b0, 32'd0, 17'd0, 7'd1));
      add_step(step_chk(KIND_FREE, 32'd4096, 1'b0, 32'd0, 17'd0, 7'd1));
      // last freed comes back first
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd8128, 17'd64, 7'd2));
      // single chunk: empty pool
      add_step(step_cfg(REG_COUNT, 32'd1));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd4096, 17'd64, 7'd1));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b0, 32'd0, 17'd0, 7'd1));
      add_step(step_chk(KIND_FREE, 32'd4096, 1'b1, 32'd0, 17'd0, 7'd0));
      // no chunks at all
      add_step(step_cfg(REG_COUNT, 32'd0));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b0, 32'd0, 17'd0, 7'd0));
      add_step(step_chk(KIND_FREE, 32'd4096, 1'b0, 32'd0, 17'd0, 7'd0));
      // count above capacity is capped
      add_step(step_cfg(REG_COUNT, 32'd127));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd8128, 17'd64, 7'd1));
      // zero size: every chunk at the base, free takes the lowest held
      add_step(step_cfg(REG_SIZE, 32'd0));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd4096, 17'd0, 7'd1));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd4096, 17'd0, 7'd2));
      add_step(step_chk(KIND_FREE, 32'd4096, 1'b1, 32'd0, 17'd0, 7'd1));
      add_step(step_req(KIND_ALLOC, 32'd0));
      // chunk at address zero cannot be freed
      add_step(step_cfg(REG_BASE, 32'd0));
      add_step(step_cfg(REG_SIZE, 32'h1_FFFF));
      add_step(step_cfg(REG_COUNT, 32'd2));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'h1_FFFF, 17'h1_FFFF, 7'd1));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd0, 17'h1_FFFF, 7'd2));
      add_step(step_chk(KIND_FREE, 32'd0, 1'b0, 32'd0, 17'd0, 7'd2));
      add_step(step_req(KIND_FREE, 32'h1_FFFF));
      // addresses wrap past the top
      add_step(step_cfg(REG_BASE, 32'hFFFF_FFFF));
      add_step(step_cfg(REG_SIZE, 32'd1));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'd0, 17'd1, 7'd1));
      add_step(step_chk(KIND_ALLOC, 32'd0, 1'b1, 32'hFFFF_FFFF, 17'd1, 7'd2));
      // write to the unused index keeps the pool as it is
      add_step(step_cfg(REG_SPARE, 32'hA5A5_5A5A));
      add_step(step_chk(KIND_FREE, 32'hFFFF_FFFF, 1'b1, 32'd0, 17'd0, 7'd1));

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed plan
      foreach (plan[k]) begin
         if (plan[k].is_write) write_register(plan[k].reg_idx, plan[k].value);
         else send_request(plan[k].item, plan[k].typed, plan[k].want, 0);
      end

      // random segments, each with its own pool shape
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(0, 3))
            0: base_v = 32'd0;
            1: base_v = 32'hFFFF_FFFF;
            2: base_v = $urandom;
            default: base_v = $urandom & 32'hFFFF_F000;
         endcase
         case ($urandom_range(0, 5))
            0: size_v = 32'd0;
            1: size_v = 32'd1;
            2: size_v = 32'd65536;
            3: size_v = 32'h1_FFFF;
            4: size_v = $urandom_range(1, 65536);
            default: size_v = $urandom_range(1, 256);
         endcase
         case ($urandom_range(0, 9))
            0: count_v = 32'd0;
            1: count_v = 32'd1;
            2: count_v = 32'd2;
            3: count_v = 32'd127;
            4: count_v = $urandom_range(65, 127);
            5, 6: count_v = 32'd64;
            default: count_v = $urandom_range(1, 16);
         endcase
         write_register(REG_BASE, base_v);
         write_register(REG_SIZE, size_v);
         write_register(REG_COUNT, count_v);
         case ($urandom_range(0, 3))
            0: alloc_pct = 35;
            1: alloc_pct = 50;
            2: alloc_pct = 65;
            default: alloc_pct = 85;
         endcase
         // sender gaps: rare, then frequent, then none
         idle_pct = (seg < 4) ? 6 : (seg < 7) ? 69 : 0;
         for (int n = 0; n < SEG_REQS; n++) begin
            send_request(random_request(alloc_pct), 1'b0, '0, idle_pct);
         end
      end

      // drain
      start = 1'b0;
      fixed_valid = 1'b0;
      while (due_replies.size() != 0) @(negedge clock);
      repeat (MAX_GAP) @(negedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/fcpa_pkg.sv
sv/fixed_chunk_pool_allocator.sv
tb/testbench.sv
